// ----- src/chamber_fan_pwm_regulator_top_defines.svh -----
// Assertion macros shared by the chamber fan regulator RTL.
`ifndef CHAMBER_FAN_PWM_REGULATOR_TOP_DEFINES_SVH
`define CHAMBER_FAN_PWM_REGULATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define CFPR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("cfpr same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CFPR_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("cfpr next-cycle check failed");

`else

`define CFPR_ASSERT_IMP(lbl, pre, post)
`define CFPR_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ----- src/cfpr_pkg.sv -----
// Types, constants and register map of the chamber fan regulator.
package cfpr_pkg;

    localparam int TEMP_W     = 12;
    localparam int DUTY_W     = 8;
    localparam int HELD_W     = 16;
    localparam int COEF_W     = 16;
    localparam int BOOST_W    = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 32;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int PROD_W     = COEF_W + 1 + ERR_W;

    typedef logic signed [ACC_W-1:0] acc_t;

    localparam logic [DUTY_W-1:0] FULL_DUTY  = 8'd255;
    localparam logic [DUTY_W-1:0] KICK_DUTY  = 8'd100;
    localparam logic [DUTY_W-1:0] FLOOR_DUTY = 8'd30;
    localparam int HYST_OFF = 26;
    localparam int HYST_ON  = 38;

    // Filter multiplier codes; the unused code acts as times one.
    localparam logic [BOOST_W-1:0] BOOST_X1 = 2'd0;
    localparam logic [BOOST_W-1:0] BOOST_X2 = 2'd1;
    localparam logic [BOOST_W-1:0] BOOST_X3 = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FLOOR_PWM = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BOOST   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_SELECT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LIMIT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_LIMIT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LIMIT  = 4'd7;

    typedef struct packed {
        logic [COEF_W-1:0]  ramp_rate;
        logic [DUTY_W-1:0]  ramp_floor_pwm;
        logic [COEF_W-1:0]  integral_gain;
        logic [BOOST_W-1:0] filter_boost;
        logic               legacy_select;
        logic [TEMP_W-1:0]  critical_limit;
        logic [TEMP_W-1:0]  overheat_limit;
        logic [TEMP_W-1:0]  release_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ramp_rate:      16'd1280,
        ramp_floor_pwm: 8'd0,
        integral_gain:  16'd256,
        filter_boost:   BOOST_X1,
        legacy_select:  1'b1,
        critical_limit: 12'd640,
        overheat_limit: 12'd560,
        release_limit:  12'd480
    };

endpackage

// ----- src/cfpr_cfg_regs.sv -----
// Configuration register file of the chamber fan regulator.
module cfpr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [cfpr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [cfpr_pkg::CFG_DATA_W-1:0] wr_data,
    output cfpr_pkg::cfg_t                 cfg
);

    cfpr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= cfpr_pkg::CFG_RESET;
        end else if (wr_en) begin
            unique case (wr_index)
                cfpr_pkg::CFG_RAMP_RATE: begin
                    cfg_reg.ramp_rate <= wr_data;
                end
                cfpr_pkg::CFG_RAMP_FLOOR_PWM: begin
                    cfg_reg.ramp_floor_pwm <= wr_data[cfpr_pkg::DUTY_W-1:0];
                end
                cfpr_pkg::CFG_INTEGRAL_GAIN: begin
                    cfg_reg.integral_gain <= wr_data;
                end
                cfpr_pkg::CFG_FILTER_BOOST: begin
                    cfg_reg.filter_boost <= wr_data[cfpr_pkg::BOOST_W-1:0];
                end
                cfpr_pkg::CFG_LEGACY_SELECT: begin
                    cfg_reg.legacy_select <= wr_data[0];
                end
                cfpr_pkg::CFG_CRITICAL_LIMIT: begin
                    cfg_reg.critical_limit <= wr_data[cfpr_pkg::TEMP_W-1:0];
                end
                cfpr_pkg::CFG_OVERHEAT_LIMIT: begin
                    cfg_reg.overheat_limit <= wr_data[cfpr_pkg::TEMP_W-1:0];
                end
                cfpr_pkg::CFG_RELEASE_LIMIT: begin
                    cfg_reg.release_limit <= wr_data[cfpr_pkg::TEMP_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/chamber_fan_pwm_regulator_top.sv -----
// Chamber fan PWM regulator: sequencer around one shared adder and one multiplier.
// The result follows the input transaction through the difference, multiply, accumulate,
// scale and limit steps; the limit step waits while the output register is full.
// A new tick is accepted only in idle, after the previous one has finished the limit step.
// Reset clears the kept output, both latches and the registers to their defaults.
`include "chamber_fan_pwm_regulator_top_defines.svh"

module chamber_fan_pwm_regulator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cfpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cfpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // tick input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [cfpr_pkg::TEMP_W-1:0] s_chamber_temp,
    input  logic                            s_goal_present,
    input  logic signed [cfpr_pkg::TEMP_W-1:0] s_goal_temp,
    input  logic                            s_auto_request,
    input  logic [cfpr_pkg::DUTY_W-1:0]     s_manual_pwm,
    input  logic [cfpr_pkg::DUTY_W-1:0]     s_auto_ceiling,
    input  logic                            s_fans_turning,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cfpr_pkg::DUTY_W-1:0]     m_fan_duty,
    output logic [cfpr_pkg::DUTY_W-1:0]     m_regulated_duty,
    output logic                            m_overheat_active,
    output logic                            m_critical_active
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_LIMIT
    } state_t;

    typedef logic signed [cfpr_pkg::PROD_W-1:0] prod_t;

    localparam int RAMP_FRAC = 11;
    localparam int LEG_FRAC  = 15;
    localparam cfpr_pkg::acc_t RAMP_OFF_LIM = cfpr_pkg::acc_t'(cfpr_pkg::HYST_OFF * 2048);
    localparam cfpr_pkg::acc_t RAMP_ON_LIM  = cfpr_pkg::acc_t'(cfpr_pkg::HYST_ON * 2048);

    cfpr_pkg::cfg_t cfg;

    state_t state_reg;
    logic   m_valid_reg;
    logic [cfpr_pkg::HELD_W-1:0] held_reg;
    logic   ovh_reg;
    logic   crit_reg;
    logic [cfpr_pkg::DUTY_W-1:0] fan_reg;
    logic [cfpr_pkg::DUTY_W-1:0] regd_reg;

    // captured tick
    logic signed [cfpr_pkg::TEMP_W-1:0] temp_reg;
    logic signed [cfpr_pkg::TEMP_W-1:0] goal_reg;
    logic                               goal_pres_reg;
    logic                               auto_reg;
    logic [cfpr_pkg::DUTY_W-1:0]        manual_reg;
    logic [cfpr_pkg::DUTY_W-1:0]        ceil_reg;
    logic                               turn_reg;

    // shared arithmetic
    cfpr_pkg::acc_t acc_reg;
    logic signed [cfpr_pkg::PROD_W-1:0] prod_reg;
    cfpr_pkg::acc_t add_a;
    cfpr_pkg::acc_t add_b;
    cfpr_pkg::acc_t sum;
    logic signed [cfpr_pkg::COEF_W:0]  mul_a;
    logic signed [cfpr_pkg::ERR_W-1:0] mul_b;
    logic signed [cfpr_pkg::PROD_W-1:0] prod;

    // limit stage
    logic           accept;
    logic           out_free;
    logic           run;
    logic           legacy;
    logic           goal_zero;
    cfpr_pkg::acc_t ceil_ramp;
    cfpr_pkg::acc_t ceil_leg;
    cfpr_pkg::acc_t ramp_v;
    cfpr_pkg::acc_t leg_s;
    logic [cfpr_pkg::HELD_W-1:0] held_next;
    logic [cfpr_pkg::DUTY_W-1:0] regd_next;
    logic [cfpr_pkg::DUTY_W-1:0] fan_next;
    logic ovh_next;
    logic crit_next;

    cfpr_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign legacy    = cfg.legacy_select;
    assign run       = auto_reg && goal_pres_reg;
    assign goal_zero = (goal_reg == '0);

    // Shared adder: difference, accumulate, then filter scaling.
    always_comb begin
        unique case (state_reg)
            S_DIFF: begin
                add_a = cfpr_pkg::acc_t'(temp_reg);
                add_b = -cfpr_pkg::acc_t'(goal_reg);
            end
            S_ACC: begin
                add_a = cfpr_pkg::acc_t'(prod_reg);
                add_b = legacy ? cfpr_pkg::acc_t'({held_reg, 7'b0})
                               : cfpr_pkg::acc_t'({cfg.ramp_floor_pwm, 11'b0});
            end
            S_SCALE: begin
                add_a = acc_reg;
                if (!legacy && cfg.filter_boost == cfpr_pkg::BOOST_X2) begin
                    add_b = acc_reg;
                end else if (!legacy && cfg.filter_boost == cfpr_pkg::BOOST_X3) begin
                    add_b = acc_reg <<< 1;
                end else begin
                    add_b = '0;
                end
            end
            default: begin
                add_a = '0;
                add_b = '0;
            end
        endcase
        sum = add_a + add_b;
    end

    // Shared multiplier: gain times signed error, or slope times positive excess.
    always_comb begin
        mul_a = legacy ? $signed({1'b0, cfg.integral_gain}) : $signed({1'b0, cfg.ramp_rate});
        if (legacy) begin
            mul_b = acc_reg[cfpr_pkg::ERR_W-1:0];
        end else if (acc_reg < 0) begin
            mul_b = '0;
        end else begin
            mul_b = acc_reg[cfpr_pkg::ERR_W-1:0];
        end
        prod = prod_t'(mul_a) * prod_t'(mul_b);
    end

    // Limit stage: hysteresis, clamps, latches and floors.
    always_comb begin
        ceil_ramp = cfpr_pkg::acc_t'({ceil_reg, {RAMP_FRAC{1'b0}}});
        ceil_leg  = cfpr_pkg::acc_t'({ceil_reg, {LEG_FRAC{1'b0}}});

        ramp_v = acc_reg;
        if (acc_reg < RAMP_OFF_LIM) begin
            ramp_v = '0;
        end else if (acc_reg < RAMP_ON_LIM && held_reg == '0) begin
            ramp_v = '0;
        end
        if (ramp_v > ceil_ramp) begin
            ramp_v = ceil_ramp;
        end

        leg_s = acc_reg;
        if (acc_reg < 0) begin
            leg_s = '0;
        end
        if (leg_s > ceil_leg) begin
            leg_s = ceil_leg;
        end

        if (!run) begin
            held_next = '0;
            regd_next = auto_reg ? '0 : manual_reg;
        end else if (legacy) begin
            held_next = leg_s[cfpr_pkg::HELD_W+6:7];
            regd_next = held_next[cfpr_pkg::HELD_W-1:8];
        end else if (goal_zero) begin
            // ramp with zero target: no duty, keep the held value
            held_next = held_reg;
            regd_next = '0;
        end else begin
            held_next = ramp_v[cfpr_pkg::HELD_W+2:3];
            regd_next = held_next[cfpr_pkg::HELD_W-1:8];
        end

        ovh_next  = ovh_reg;
        crit_next = crit_reg;
        priority if (temp_reg >= $signed(cfg.critical_limit)) begin
            crit_next = 1'b1;
        end else if (temp_reg >= $signed(cfg.overheat_limit)) begin
            ovh_next = 1'b1;
        end else if (temp_reg < $signed(cfg.release_limit)) begin
            ovh_next  = 1'b0;
            crit_next = 1'b0;
        end else begin
            // hold both latches
        end

        priority if (ovh_next || crit_next) begin
            fan_next = cfpr_pkg::FULL_DUTY;
        end else if (regd_next == '0) begin
            fan_next = '0;
        end else if (!turn_reg) begin
            fan_next = (regd_next > cfpr_pkg::KICK_DUTY) ? regd_next : cfpr_pkg::KICK_DUTY;
        end else begin
            fan_next = (regd_next > cfpr_pkg::FLOOR_DUTY) ? regd_next : cfpr_pkg::FLOOR_DUTY;
        end
    end

    // Sequencer, kept state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
            ovh_reg     <= 1'b0;
            crit_reg    <= 1'b0;
        end else begin
            if (state_reg == S_LIMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    state_reg <= S_LIMIT;
                end
                S_LIMIT: begin
                    // hold until the previous transaction has left the output register
                    if (out_free) begin
                        held_reg  <= held_next;
                        ovh_reg   <= ovh_next;
                        crit_reg  <= crit_next;
                        fan_reg   <= fan_next;
                        regd_reg  <= regd_next;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Input capture and working registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            temp_reg      <= s_chamber_temp;
            goal_reg      <= s_goal_temp;
            goal_pres_reg <= s_goal_present;
            auto_reg      <= s_auto_request;
            manual_reg    <= s_manual_pwm;
            ceil_reg      <= s_auto_ceiling;
            turn_reg      <= s_fans_turning;
        end
        if (state_reg == S_DIFF || state_reg == S_ACC || state_reg == S_SCALE) begin
            acc_reg <= sum;
        end
        if (state_reg == S_MUL) begin
            prod_reg <= prod;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fan_duty        = fan_reg;
    assign m_regulated_duty  = regd_reg;
    assign m_overheat_active = ovh_reg;
    assign m_critical_active = crit_reg;

    `CFPR_ASSERT_IMP(a_latch_forces_full,
        m_valid && (m_overheat_active || m_critical_active),
        m_fan_duty == cfpr_pkg::FULL_DUTY)
    `CFPR_ASSERT_IMP(a_zero_duty_stays_zero,
        m_valid && !m_overheat_active && !m_critical_active && m_regulated_duty == '0,
        m_fan_duty == '0)
    `CFPR_ASSERT_IMP(a_floor_applied,
        m_valid && !m_overheat_active && !m_critical_active && m_regulated_duty != '0,
        m_fan_duty >= m_regulated_duty && m_fan_duty >= cfpr_pkg::FLOOR_DUTY)
    `CFPR_ASSERT_NXT(a_one_tick_in_flight,
        s_valid && s_ready,
        !s_ready)
    `CFPR_ASSERT_NXT(a_held_cleared_without_goal,
        state_reg == S_LIMIT && out_free && !run,
        held_reg == '0)

endmodule

// ----- tb/sv/chamber_fan_pwm_regulator_top_tb.sv -----
// Self-checking testbench for the chamber fan PWM regulator.
module chamber_fan_pwm_regulator_top_tb;
    import cfpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASES         = 8;
    localparam int TICKS_PER_PHASE = 125;
    localparam logic [BOOST_W-1:0] BOOST_UNUSED = 2'd3;

    typedef struct {
        logic signed [TEMP_W-1:0] chamber_temp;
        logic                     goal_present;
        logic signed [TEMP_W-1:0] goal_temp;
        logic                     auto_request;
        logic [DUTY_W-1:0]        manual_pwm;
        logic [DUTY_W-1:0]        auto_ceiling;
        logic                     fans_turning;
    } tick_t;

    typedef struct {
        logic [DUTY_W-1:0] fan_duty;
        logic [DUTY_W-1:0] regulated_duty;
        logic              overheat_active;
        logic              critical_active;
    } duty_result_t;

    class duty_scoreboard;
        cfg_t              regs;
        logic [HELD_W-1:0] held;
        bit                overheat;
        bit                critical;
        duty_result_t      expected_q[$];
        int                mismatches;

        function new();
            regs = CFG_RESET;
            held = '0;
            overheat = 1'b0;
            critical = 1'b0;
            mismatches = 0;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RAMP_RATE:      regs.ramp_rate = data;
                CFG_RAMP_FLOOR_PWM: regs.ramp_floor_pwm = data[DUTY_W-1:0];
                CFG_INTEGRAL_GAIN:  regs.integral_gain = data;
                CFG_FILTER_BOOST:   regs.filter_boost = data[BOOST_W-1:0];
                CFG_LEGACY_SELECT:  regs.legacy_select = data[0];
                CFG_CRITICAL_LIMIT: regs.critical_limit = data[TEMP_W-1:0];
                CFG_OVERHEAT_LIMIT: regs.overheat_limit = data[TEMP_W-1:0];
                CFG_RELEASE_LIMIT:  regs.release_limit = data[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // Work out the duty for one accepted tick and queue it.
        function void note_tick(tick_t t);
            duty_result_t      r;
            longint            temp_v;
            longint            err;
            longint            acc;
            longint            mult;
            logic [DUTY_W-1:0] reg_duty;
            temp_v = t.chamber_temp;
            err = temp_v - longint'(t.goal_temp);
            if (t.auto_request && t.goal_present) begin
                if (regs.legacy_select) begin
                    acc = longint'(held) * 128 + longint'(regs.integral_gain) * err;
                    if (acc < 0)
                        acc = 0;
                    if (acc > longint'(t.auto_ceiling) * 32768)
                        acc = longint'(t.auto_ceiling) * 32768;
                    held = HELD_W'(acc >> 7);
                    reg_duty = held[HELD_W-1:8];
                end else if (t.goal_temp == 0) begin
                    // hold the kept output
                    reg_duty = '0;
                end else begin
                    case (regs.filter_boost)
                        BOOST_X2: mult = 2;
                        BOOST_X3: mult = 3;
                        default:  mult = 1;
                    endcase
                    if (err < 0)
                        err = 0;
                    acc = (err * longint'(regs.ramp_rate)
                           + longint'(regs.ramp_floor_pwm) * 2048) * mult;
                    if (acc < HYST_OFF * 2048)
                        acc = 0;
                    else if (acc < HYST_ON * 2048 && held == 0)
                        acc = 0;
                    if (acc > longint'(t.auto_ceiling) * 2048)
                        acc = longint'(t.auto_ceiling) * 2048;
                    held = HELD_W'(acc >> 3);
                    reg_duty = held[HELD_W-1:8];
                end
            end else begin
                reg_duty = t.auto_request ? '0 : t.manual_pwm;
                held = '0;
            end

            if (temp_v >= longint'($signed(regs.critical_limit)))
                critical = 1'b1;
            else if (temp_v >= longint'($signed(regs.overheat_limit)))
                overheat = 1'b1;
            else if (temp_v < longint'($signed(regs.release_limit))) begin
                overheat = 1'b0;
                critical = 1'b0;
            end

            if (overheat || critical)
                r.fan_duty = FULL_DUTY;
            else if (reg_duty == 0)
                r.fan_duty = '0;
            else if (!t.fans_turning)
                r.fan_duty = (reg_duty > KICK_DUTY) ? reg_duty : KICK_DUTY;
            else
                r.fan_duty = (reg_duty > FLOOR_DUTY) ? reg_duty : FLOOR_DUTY;
            r.regulated_duty = reg_duty;
            r.overheat_active = overheat;
            r.critical_active = critical;
            expected_q.push_back(r);
        endfunction

        function void check_result(duty_result_t got);
            duty_result_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result fan=%0d reg=%0d oh=%0d crit=%0d",
                    got.fan_duty, got.regulated_duty, got.overheat_active,
                    got.critical_active));
                return;
            end
            want = expected_q.pop_front();
            if (got.fan_duty !== want.fan_duty
                || got.regulated_duty !== want.regulated_duty
                || got.overheat_active !== want.overheat_active
                || got.critical_active !== want.critical_active)
                flag($sformatf("fan %0d/%0d reg %0d/%0d oh %0d/%0d crit %0d/%0d (exp/got)",
                    want.fan_duty, got.fan_duty, want.regulated_duty, got.regulated_duty,
                    want.overheat_active, got.overheat_active,
                    want.critical_active, got.critical_active));
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [TEMP_W-1:0]  s_chamber_temp = '0;
    logic                      s_goal_present = 1'b0;
    logic signed [TEMP_W-1:0]  s_goal_temp = '0;
    logic                      s_auto_request = 1'b0;
    logic [DUTY_W-1:0]         s_manual_pwm = '0;
    logic [DUTY_W-1:0]         s_auto_ceiling = '0;
    logic                      s_fans_turning = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [DUTY_W-1:0]         m_fan_duty;
    logic [DUTY_W-1:0]         m_regulated_duty;
    logic                      m_overheat_active;
    logic                      m_critical_active;

    int send_idle_pct = 0;
    int stall_pct = 0;
    duty_scoreboard board = new();

    chamber_fan_pwm_regulator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_chamber_temp(s_chamber_temp), .s_goal_present(s_goal_present),
        .s_goal_temp(s_goal_temp), .s_auto_request(s_auto_request),
        .s_manual_pwm(s_manual_pwm), .s_auto_ceiling(s_auto_ceiling),
        .s_fans_turning(s_fans_turning),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_fan_duty(m_fan_duty), .m_regulated_duty(m_regulated_duty),
        .m_overheat_active(m_overheat_active), .m_critical_active(m_critical_active)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_fan_duty, m_regulated_duty,
                                 m_overheat_active, m_critical_active});
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic int pick_value(int lo, int hi, int typ_lo, int typ_hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return typ_lo + int'($urandom_range(0, typ_hi - typ_lo));
        endcase
    endfunction

    function automatic tick_t mk_tick(int temp, int goal_p, int goal, int auto_r,
                                      int manual, int ceiling, int turning);
        tick_t t;
        t.chamber_temp = TEMP_W'(temp);
        t.goal_present = goal_p[0];
        t.goal_temp = TEMP_W'(goal);
        t.auto_request = auto_r[0];
        t.manual_pwm = DUTY_W'(manual);
        t.auto_ceiling = DUTY_W'(ceiling);
        t.fans_turning = turning[0];
        return t;
    endfunction

    function automatic tick_t random_tick();
        int sel;
        int goal;
        int temp;
        int ceiling;
        sel = $urandom_range(0, 99);
        goal = ($urandom_range(0, 19) == 0) ? 0 : pick_value(-400, 1600, -400, 1600);
        if ($urandom_range(0, 9) < 6) begin
            // stay near the target so the regulators see small errors
            temp = goal - 40 + int'($urandom_range(0, 240));
            if (temp > 1600)
                temp = 1600;
            if (temp < -400)
                temp = -400;
        end else
            temp = pick_value(-400, 1600, -400, 1600);
        case ($urandom_range(0, 19))
            0: ceiling = 0;
            1, 2: ceiling = 255;
            default: ceiling = $urandom_range(0, 255);
        endcase
        return mk_tick(temp,
                       (sel < 70) ? 1 : ((sel < 80) ? 0 : int'($urandom_range(0, 1))),
                       goal, (sel < 80) ? 1 : 0, pick_value(0, 255, 0, 255), ceiling,
                       $urandom_range(0, 1));
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        int   lims[$];
        c.ramp_rate = COEF_W'(pick_value(0, 65535, 64, 4096));
        c.ramp_floor_pwm = DUTY_W'(pick_value(0, 255, 0, 40));
        c.integral_gain = COEF_W'(pick_value(0, 65535, 16, 2048));
        c.filter_boost = BOOST_W'($urandom_range(0, 3));
        c.legacy_select = 1'($urandom_range(0, 1));
        repeat (3) lims.push_back(pick_value(-400, 1600, -400, 1600));
        if ($urandom_range(0, 3) != 0)
            lims.sort();
        c.release_limit = TEMP_W'(lims[0]);
        c.overheat_limit = TEMP_W'(lims[1]);
        c.critical_limit = TEMP_W'(lims[2]);
        return c;
    endfunction

    task automatic send_tick(tick_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_chamber_temp <= t.chamber_temp;
        s_goal_present <= t.goal_present;
        s_goal_temp <= t.goal_temp;
        s_auto_request <= t.auto_request;
        s_manual_pwm <= t.manual_pwm;
        s_auto_ceiling <= t.auto_ceiling;
        s_fans_turning <= t.fans_turning;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(t);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cfg_valid <= 1'b0;
            @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.note_write(idx, data);
    endtask

    // Write every register, with junk above the width of the narrower ones, plus one unmapped index.
    task automatic apply_config(cfg_t c);
        write_reg(CFG_RAMP_RATE, c.ramp_rate);
        write_reg(CFG_RAMP_FLOOR_PWM, {8'($urandom), c.ramp_floor_pwm});
        write_reg(CFG_INTEGRAL_GAIN, c.integral_gain);
        write_reg(CFG_FILTER_BOOST, {14'($urandom), c.filter_boost});
        write_reg(CFG_LEGACY_SELECT, {15'($urandom), c.legacy_select});
        write_reg(CFG_CRITICAL_LIMIT, {4'($urandom), c.critical_limit});
        write_reg(CFG_OVERHEAT_LIMIT, {4'($urandom), c.overheat_limit});
        write_reg(CFG_RELEASE_LIMIT, {4'($urandom), c.release_limit});
        write_reg(CFG_IDX_W'($urandom_range(CFG_RELEASE_LIMIT + 1, 2**CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        cfg_t c;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Legacy regulator, manual duty and latch behavior at reset settings.
        c = CFG_RESET;
        wait_drained();
        apply_config(c);
        send_tick(mk_tick(200, 0, 0, 0, 0, 255, 1));
        send_tick(mk_tick(-400, 1, 100, 0, 255, 0, 0));
        send_tick(mk_tick(100, 0, 0, 0, 10, 255, 0));
        send_tick(mk_tick(100, 1, -400, 0, 10, 255, 1));
        send_tick(mk_tick(100, 0, 0, 1, 200, 255, 1));
        send_tick(mk_tick(1600, 1, -400, 1, 0, 255, 1));
        send_tick(mk_tick(500, 1, 400, 1, 0, 128, 0));
        send_tick(mk_tick(479, 1, 1600, 1, 0, 255, 1));
        send_tick(mk_tick(560, 1, 560, 1, 0, 0, 1));
        send_tick(mk_tick(640, 1, 600, 1, 0, 255, 0));
        send_tick(mk_tick(-400, 1, 0, 1, 0, 255, 1));

        // Ramp regulator: goal zero, hysteresis band, ceiling, negative excess.
        wait_drained();
        c.legacy_select = 1'b0;
        apply_config(c);
        send_tick(mk_tick(300, 1, 0, 1, 0, 255, 1));
        send_tick(mk_tick(248, 1, 200, 1, 0, 255, 1));
        send_tick(mk_tick(300, 1, 200, 1, 0, 255, 0));
        send_tick(mk_tick(248, 1, 200, 1, 0, 255, 1));
        send_tick(mk_tick(210, 1, 200, 1, 0, 255, 1));
        send_tick(mk_tick(1600, 1, -400, 1, 0, 200, 1));
        send_tick(mk_tick(-400, 1, 1600, 1, 0, 255, 1));

        wait_drained();
        c.filter_boost = BOOST_X3;
        c.ramp_floor_pwm = 8'd20;
        c.ramp_rate = 16'hFFFF;
        apply_config(c);
        send_tick(mk_tick(100, 1, 100, 1, 0, 255, 1));
        send_tick(mk_tick(101, 1, 100, 1, 0, 255, 0));
        send_tick(mk_tick(101, 1, 100, 1, 0, 0, 1));

        wait_drained();
        c.filter_boost = BOOST_UNUSED;
        apply_config(c);
        send_tick(mk_tick(100, 1, 100, 1, 0, 255, 1));
        send_tick(mk_tick(110, 1, 100, 1, 0, 255, 1));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            apply_config(random_config());
            repeat (TICKS_PER_PHASE) send_tick(random_tick());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.expected_q.size() != 0)
            board.flag($sformatf("%0d results never arrived", board.expected_q.size()));
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
